>>> design/deg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deg_pkg: dual envelope generator shared definitions
// Word codes, stage encodings, field widths and register reset values.
// ----------------------------------------------------------------------------
package deg_pkg;

	localparam int OP_W      = 2;
	localparam int COEF_W    = 24;
	localparam int FIELD_W   = 25;
	localparam int APHASE_W  = 3;
	localparam int FPHASE_W  = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
	localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_AMP_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_RELEASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_SUSTAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLT_ATTACK  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FLT_RELEASE = 3'd5;

	localparam logic [COEF_W-1:0]  RST_AMP_ATTACK  = 24'd34914;
	localparam logic [COEF_W-1:0]  RST_AMP_DECAY   = 24'd3495;
	localparam logic [COEF_W-1:0]  RST_AMP_RELEASE = 24'd3495;
	localparam logic [FIELD_W-1:0] RST_AMP_SUSTAIN = 25'd11744051;
	localparam logic [COEF_W-1:0]  RST_FLT_ATTACK  = 24'd34914;
	localparam logic [COEF_W-1:0]  RST_FLT_RELEASE = 24'd3495;

	typedef enum logic [APHASE_W-1:0] {
		AMP_IDLE    = 3'd0,
		AMP_ATTACK  = 3'd1,
		AMP_DECAY   = 3'd2,
		AMP_SUSTAIN = 3'd3,
		AMP_RELEASE = 3'd4
	} amp_stage_t;

	typedef enum logic [FPHASE_W-1:0] {
		FLT_IDLE    = 2'd0,
		FLT_ATTACK  = 2'd1,
		FLT_HOLD    = 2'd2,
		FLT_RELEASE = 2'd3
	} flt_stage_t;

endpackage
`default_nettype wire

>>> design/deg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deg_in_if: event channel
// Carries tick, note-on and note-off words with the retrigger flag.
// ----------------------------------------------------------------------------
interface deg_in_if import deg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	logic            retrigger;

	modport source (output valid, op, retrigger, input ready);
	modport sink   (input valid, op, retrigger, output ready);
endinterface
`default_nettype wire

>>> design/deg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deg_out_if: envelope result channel
// Carries both levels, both phases and the voice status flags.
// ----------------------------------------------------------------------------
interface deg_out_if import deg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  amp_level;
	logic [FIELD_W-1:0]  filter_level;
	logic [APHASE_W-1:0] amp_phase;
	logic [FPHASE_W-1:0] filter_phase;
	logic                voice_active;
	logic                gate_held;

	modport source (output valid, amp_level, filter_level, amp_phase, filter_phase,
		voice_active, gate_held, input ready);
	modport sink   (input valid, amp_level, filter_level, amp_phase, filter_phase,
		voice_active, gate_held, output ready);
endinterface
`default_nettype wire

>>> design/deg_approach.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deg_approach: exponential approach step
// Moves a level toward a target by (|target - level| * coef) >> 24, at least
// one LSB and never past the target.
// ----------------------------------------------------------------------------
module deg_approach import deg_pkg::*; #(
	parameter int LW = 25
) (
	input  wire logic [LW-1:0]     level,
	input  wire logic [LW-1:0]     target,
	input  wire logic [COEF_W-1:0] coef,
	output logic      [LW-1:0]     next_level
);

	logic                 up;
	logic [LW-1:0]        diff;
	logic [LW+COEF_W-1:0] prod;
	logic [LW-1:0]        step;
	logic [LW-1:0]        step_c;

	assign up     = target > level;
	assign diff   = up ? (target - level) : (level - target);
	assign prod   = (LW+COEF_W)'(diff) * (LW+COEF_W)'(coef);
	assign step   = prod[LW+COEF_W-1:COEF_W];
	// floor of a nonzero diff times a fraction stays below diff
	assign step_c = (step == '0) ? LW'(1) : step;

	always_comb begin
		if (level == target) begin
			next_level = level;
		end else if (up) begin
			next_level = level + step_c;
		end else begin
			next_level = level - step_c;
		end
	end

endmodule
`default_nettype wire

>>> design/dual_envelope_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_envelope_generator_top: amplitude and filter envelopes for one voice
// Exponential ADSR amplitude envelope and AHR filter envelope, driven by
// tick, note-on and note-off words, with a plain register write port.
// ----------------------------------------------------------------------------
// Each event word yields exactly one result word. A taken word waits in the
// input register, then passes through the envelope update into the state
// registers that drive the result. A new word is taken every cycle while the
// result side keeps up; the figure is set by the state loop, which holds one
// approach multiply (level difference times coefficient) per envelope. Registers
// are to be written by the user only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_envelope_generator_top import deg_pkg::*; #(
	parameter int LEVEL_FRAC_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [FIELD_W-1:0]   cfg_data,
	deg_in_if.sink                    evt,
	deg_out_if.source                 env
);

	localparam int LW = LEVEL_FRAC_BITS + 1;
	localparam int CW = (LW > FIELD_W) ? LW : FIELD_W;
	localparam logic [63:0] ONE64 = 64'd1 << LEVEL_FRAC_BITS;
	localparam logic [LW-1:0] ONE         = LW'(ONE64);
	localparam logic [LW-1:0] ATTACK_DONE = LW'(ONE64 - (ONE64 * 64'd5 + 64'd5000) / 64'd10000);
	localparam logic [LW-1:0] DECAY_TOL   = LW'((ONE64 * 64'd15 + 64'd5000) / 64'd10000);
	localparam logic [LW-1:0] REL_FLOOR   = LW'((ONE64 + 64'd5000) / 64'd10000);
	localparam logic [CW-1:0] ONE_CW      = CW'(ONE64);

	// registers
	logic [COEF_W-1:0]  amp_attack_q, amp_decay_q, amp_release_q;
	logic [COEF_W-1:0]  flt_attack_q, flt_release_q;
	logic [FIELD_W-1:0] amp_sustain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_attack_q  <= RST_AMP_ATTACK;
			amp_decay_q   <= RST_AMP_DECAY;
			amp_release_q <= RST_AMP_RELEASE;
			amp_sustain_q <= RST_AMP_SUSTAIN;
			flt_attack_q  <= RST_FLT_ATTACK;
			flt_release_q <= RST_FLT_RELEASE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_AMP_ATTACK:  amp_attack_q  <= cfg_data[COEF_W-1:0];
				CFG_AMP_DECAY:   amp_decay_q   <= cfg_data[COEF_W-1:0];
				CFG_AMP_RELEASE: amp_release_q <= cfg_data[COEF_W-1:0];
				CFG_AMP_SUSTAIN: amp_sustain_q <= cfg_data;
				CFG_FLT_ATTACK:  flt_attack_q  <= cfg_data[COEF_W-1:0];
				CFG_FLT_RELEASE: flt_release_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// input register and handshake
	logic            valid_s1;
	logic [OP_W-1:0] op_s1;
	logic            retrig_s1;
	logic            out_valid_q;
	logic            adv;

	assign adv       = valid_s1 && (!out_valid_q || env.ready);
	assign evt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			op_s1     <= evt.op;
			retrig_s1 <= evt.retrigger;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (env.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// envelope state
	logic [LW-1:0] amp_value_q, flt_value_q;
	amp_stage_t    amp_stage_q;
	flt_stage_t    flt_stage_q;
	logic          gate_q, active_q;

	logic [LW-1:0] amp_value_d, flt_value_d;
	amp_stage_t    amp_stage_d;
	flt_stage_t    flt_stage_d;
	logic          gate_d, active_d;

	logic [CW-1:0]     sus_cw;
	logic [LW-1:0]     sus;
	logic [LW-1:0]     amp_tgt, flt_tgt;
	logic [COEF_W-1:0] amp_coef, flt_coef;
	logic [LW-1:0]     amp_step, flt_step;
	logic [LW-1:0]     amp_dev;

	assign sus_cw = CW'(amp_sustain_q);
	assign sus    = (sus_cw > ONE_CW) ? ONE : LW'(sus_cw);

	always_comb begin
		unique case (amp_stage_q)
			AMP_ATTACK: begin
				amp_tgt  = ONE;
				amp_coef = amp_attack_q;
			end
			AMP_DECAY: begin
				amp_tgt  = sus;
				amp_coef = amp_decay_q;
			end
			default: begin
				amp_tgt  = '0;
				amp_coef = amp_release_q;
			end
		endcase
		flt_tgt  = (flt_stage_q == FLT_ATTACK) ? ONE : '0;
		flt_coef = (flt_stage_q == FLT_ATTACK) ? flt_attack_q : flt_release_q;
	end

	deg_approach #(.LW(LW)) u_amp_approach (
		.level      (amp_value_q),
		.target     (amp_tgt),
		.coef       (amp_coef),
		.next_level (amp_step)
	);

	deg_approach #(.LW(LW)) u_flt_approach (
		.level      (flt_value_q),
		.target     (flt_tgt),
		.coef       (flt_coef),
		.next_level (flt_step)
	);

	assign amp_dev = (amp_step > sus) ? (amp_step - sus) : (sus - amp_step);

	always_comb begin
		amp_value_d = amp_value_q;
		flt_value_d = flt_value_q;
		amp_stage_d = amp_stage_q;
		flt_stage_d = flt_stage_q;
		gate_d      = gate_q;
		active_d    = active_q;
		unique case (op_s1)
			OP_TICK: begin
				if (active_q) begin
					unique case (amp_stage_q)
						AMP_ATTACK: begin
							if (amp_step >= ATTACK_DONE) begin
								amp_value_d = ONE;
								amp_stage_d = AMP_DECAY;
							end else begin
								amp_value_d = amp_step;
							end
						end
						AMP_DECAY: begin
							if (amp_dev <= DECAY_TOL) begin
								amp_value_d = sus;
								amp_stage_d = gate_q ? AMP_SUSTAIN : AMP_RELEASE;
							end else begin
								amp_value_d = amp_step;
							end
						end
						AMP_SUSTAIN: begin
							amp_value_d = sus;
							if (!gate_q) amp_stage_d = AMP_RELEASE;
						end
						AMP_RELEASE: begin
							if (amp_step <= REL_FLOOR) begin
								amp_value_d = '0;
								amp_stage_d = AMP_IDLE;
							end else begin
								amp_value_d = amp_step;
							end
						end
						default: begin
							amp_value_d = '0;
							amp_stage_d = AMP_IDLE;
						end
					endcase
					unique case (flt_stage_q)
						FLT_ATTACK: begin
							if (flt_step >= ATTACK_DONE) begin
								flt_value_d = ONE;
								flt_stage_d = gate_q ? FLT_HOLD : FLT_RELEASE;
							end else begin
								flt_value_d = flt_step;
							end
						end
						FLT_HOLD: begin
							if (!gate_q) flt_stage_d = FLT_RELEASE;
						end
						FLT_RELEASE: begin
							if (flt_step <= REL_FLOOR) begin
								flt_value_d = '0;
								flt_stage_d = FLT_IDLE;
							end else begin
								flt_value_d = flt_step;
							end
						end
						default: flt_value_d = '0;
					endcase
					if (amp_stage_d == AMP_IDLE && !gate_q) active_d = 1'b0;
				end
			end
			OP_NOTE_ON: begin
				active_d = 1'b1;
				gate_d   = 1'b1;
				if (retrig_s1) begin
					amp_value_d = '0;
					flt_value_d = '0;
					amp_stage_d = AMP_ATTACK;
					flt_stage_d = FLT_ATTACK;
				end else begin
					if (amp_stage_q == AMP_IDLE || amp_stage_q == AMP_RELEASE)
						amp_stage_d = AMP_ATTACK;
					if (flt_stage_q == FLT_IDLE || flt_stage_q == FLT_RELEASE)
						flt_stage_d = FLT_ATTACK;
				end
			end
			OP_NOTE_OFF: begin
				gate_d = 1'b0;
				if (amp_stage_q != AMP_IDLE) amp_stage_d = AMP_RELEASE;
				if (flt_stage_q != FLT_IDLE) flt_stage_d = FLT_RELEASE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_value_q <= '0;
			flt_value_q <= '0;
			amp_stage_q <= AMP_IDLE;
			flt_stage_q <= FLT_IDLE;
			gate_q      <= 1'b0;
			active_q    <= 1'b0;
		end else if (adv) begin
			amp_value_q <= amp_value_d;
			flt_value_q <= flt_value_d;
			amp_stage_q <= amp_stage_d;
			flt_stage_q <= flt_stage_d;
			gate_q      <= gate_d;
			active_q    <= active_d;
		end
	end

	// result word: state only moves when the result register is free
	logic [CW-1:0] amp_ext, flt_ext;

	assign amp_ext = CW'(amp_value_q);
	assign flt_ext = CW'(flt_value_q);

	assign env.valid        = out_valid_q;
	assign env.amp_level    = amp_ext[FIELD_W-1:0];
	assign env.filter_level = flt_ext[FIELD_W-1:0];
	assign env.amp_phase    = amp_stage_q;
	assign env.filter_phase = flt_stage_q;
	assign env.voice_active = active_q;
	assign env.gate_held    = gate_q;

endmodule
`default_nettype wire

>>> tb/deg_env_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deg_env_checker: envelope prediction and result comparison
// Watches the register port and both channels. Each word taken on the event
// channel is run through a cycle-free copy of the envelope behaviour. The
// predicted levels, phases and flags are queued and compared field by field
// with each word taken on the result channel.
// ----------------------------------------------------------------------------
module deg_env_checker import deg_pkg::*; #(
	parameter int LEVEL_FRAC_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [FIELD_W-1:0]   cfg_data,
	deg_in_if                         evt,
	deg_out_if                        env,
	output int                        fail_count,
	output int                        pending
);

	localparam longint unsigned FULL        = 64'd1 << LEVEL_FRAC_BITS;
	localparam longint unsigned ATTACK_END  = FULL - (FULL * 5 + 5000) / 10000;
	localparam longint unsigned DECAY_BAND  = (FULL * 15 + 5000) / 10000;
	localparam longint unsigned RELEASE_END = (FULL + 5000) / 10000;

	typedef struct packed {
		logic [FIELD_W-1:0]  amp_level;
		logic [FIELD_W-1:0]  filter_level;
		logic [APHASE_W-1:0] amp_phase;
		logic [FPHASE_W-1:0] filter_phase;
		logic                voice_active;
		logic                gate_held;
	} env_word_t;

	// register copies
	logic [COEF_W-1:0]  k_amp_att, k_amp_dec, k_amp_rel, k_flt_att, k_flt_rel;
	logic [FIELD_W-1:0] sus_reg;

	// voice state
	logic [FIELD_W-1:0] amp_lvl, flt_lvl;
	amp_stage_t         amp_st;
	flt_stage_t         flt_st;
	logic               gate_on, sounding;

	env_word_t due_envelopes[$];
	env_word_t want, got;

	function automatic logic [FIELD_W-1:0] approach_level(input logic [FIELD_W-1:0] lvl,
		input logic [FIELD_W-1:0] target, input logic [COEF_W-1:0] k);
		longint unsigned gap, stride;
		if (lvl == target)
			return lvl;
		gap = (lvl > target) ? lvl - target : target - lvl;
		stride = (gap * k) >> COEF_W;
		if (stride == 0)
			stride = 1;
		if (stride > gap)
			stride = gap;
		return (lvl > target) ? lvl - FIELD_W'(stride) : lvl + FIELD_W'(stride);
	endfunction

	task automatic step_voice(input logic [OP_W-1:0] op, input logic rt);
		longint unsigned sus, d;
		sus = (sus_reg > FULL) ? FULL : sus_reg;
		case (op)
		OP_TICK: begin
			if (sounding) begin
				case (amp_st)
				AMP_ATTACK: begin
					amp_lvl = approach_level(amp_lvl, FIELD_W'(FULL), k_amp_att);
					if (amp_lvl >= ATTACK_END) begin
						amp_lvl = FIELD_W'(FULL);
						amp_st  = AMP_DECAY;
					end
				end
				AMP_DECAY: begin
					amp_lvl = approach_level(amp_lvl, FIELD_W'(sus), k_amp_dec);
					d = (amp_lvl > sus) ? amp_lvl - sus : sus - amp_lvl;
					if (d <= DECAY_BAND) begin
						amp_lvl = FIELD_W'(sus);
						amp_st  = gate_on ? AMP_SUSTAIN : AMP_RELEASE;
					end
				end
				AMP_SUSTAIN: begin
					amp_lvl = FIELD_W'(sus);
					if (!gate_on)
						amp_st = AMP_RELEASE;
				end
				AMP_RELEASE: begin
					amp_lvl = approach_level(amp_lvl, '0, k_amp_rel);
					if (amp_lvl <= RELEASE_END) begin
						amp_lvl = '0;
						amp_st  = AMP_IDLE;
					end
				end
				default: begin
					amp_st  = AMP_IDLE;
					amp_lvl = '0;
				end
				endcase
				case (flt_st)
				FLT_ATTACK: begin
					flt_lvl = approach_level(flt_lvl, FIELD_W'(FULL), k_flt_att);
					if (flt_lvl >= ATTACK_END) begin
						flt_lvl = FIELD_W'(FULL);
						flt_st  = gate_on ? FLT_HOLD : FLT_RELEASE;
					end
				end
				FLT_HOLD: begin
					if (!gate_on)
						flt_st = FLT_RELEASE;
				end
				FLT_RELEASE: begin
					flt_lvl = approach_level(flt_lvl, '0, k_flt_rel);
					if (flt_lvl <= RELEASE_END) begin
						flt_lvl = '0;
						flt_st  = FLT_IDLE;
					end
				end
				default: flt_lvl = '0;
				endcase
				if (amp_st == AMP_IDLE && !gate_on)
					sounding = 1'b0;
			end
		end
		OP_NOTE_ON: begin
			sounding = 1'b1;
			gate_on  = 1'b1;
			if (rt) begin
				amp_lvl = '0;
				flt_lvl = '0;
				amp_st  = AMP_ATTACK;
				flt_st  = FLT_ATTACK;
			end else begin
				if (amp_st == AMP_IDLE || amp_st == AMP_RELEASE)
					amp_st = AMP_ATTACK;
				if (flt_st == FLT_IDLE || flt_st == FLT_RELEASE)
					flt_st = FLT_ATTACK;
			end
		end
		OP_NOTE_OFF: begin
			gate_on = 1'b0;
			if (amp_st != AMP_IDLE)
				amp_st = AMP_RELEASE;
			if (flt_st != FLT_IDLE)
				flt_st = FLT_RELEASE;
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_amp_att  = RST_AMP_ATTACK;
			k_amp_dec  = RST_AMP_DECAY;
			k_amp_rel  = RST_AMP_RELEASE;
			sus_reg    = RST_AMP_SUSTAIN;
			k_flt_att  = RST_FLT_ATTACK;
			k_flt_rel  = RST_FLT_RELEASE;
			amp_lvl    = '0;
			flt_lvl    = '0;
			amp_st     = AMP_IDLE;
			flt_st     = FLT_IDLE;
			gate_on    = 1'b0;
			sounding   = 1'b0;
			due_envelopes.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
				CFG_AMP_ATTACK:  k_amp_att = cfg_data[COEF_W-1:0];
				CFG_AMP_DECAY:   k_amp_dec = cfg_data[COEF_W-1:0];
				CFG_AMP_RELEASE: k_amp_rel = cfg_data[COEF_W-1:0];
				CFG_AMP_SUSTAIN: sus_reg   = cfg_data;
				CFG_FLT_ATTACK:  k_flt_att = cfg_data[COEF_W-1:0];
				CFG_FLT_RELEASE: k_flt_rel = cfg_data[COEF_W-1:0];
				default: ;
				endcase
			end
			if (evt.valid && evt.ready) begin
				step_voice(evt.op, evt.retrigger);
				want.amp_level    = amp_lvl;
				want.filter_level = flt_lvl;
				want.amp_phase    = amp_st;
				want.filter_phase = flt_st;
				want.voice_active = sounding;
				want.gate_held    = gate_on;
				due_envelopes.push_back(want);
			end
			if (env.valid && env.ready) begin
				got.amp_level    = env.amp_level;
				got.filter_level = env.filter_level;
				got.amp_phase    = env.amp_phase;
				got.filter_phase = env.filter_phase;
				got.voice_active = env.voice_active;
				got.gate_held    = env.gate_held;
				if (due_envelopes.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result word amp %0d flt %0d", $time,
							got.amp_level, got.filter_level);
					fail_count++;
				end else begin
					want = due_envelopes.pop_front();
					if (got.amp_level !== want.amp_level ||
						got.filter_level !== want.filter_level ||
						got.amp_phase !== want.amp_phase ||
						got.filter_phase !== want.filter_phase ||
						got.voice_active !== want.voice_active ||
						got.gate_held !== want.gate_held) begin
						if (fail_count < 10) begin
							$display("%0t: result word differs", $time);
							$display("  expected amp %0d flt %0d aph %0d fph %0d act %0b gate %0b",
								want.amp_level, want.filter_level, want.amp_phase,
								want.filter_phase, want.voice_active, want.gate_held);
							$display("  actual   amp %0d flt %0d aph %0d fph %0d act %0b gate %0b",
								got.amp_level, got.filter_level, got.amp_phase,
								got.filter_phase, got.voice_active, got.gate_held);
						end
						fail_count++;
					end
				end
			end
			pending = due_envelopes.size();
		end
	end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: dual envelope generator testbench
// Drives event words with random gaps and a randomly stalling result side,
// first a short directed run under reset settings, then random note phrases
// and stray words across several register settings (fast, zero and random
// coefficients, sustain at zero, full scale and above). The checker predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import deg_pkg::*; ();

	localparam int FRAC_BITS    = 24;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int PHASES       = 9;

	// spare op code, ignored by the block
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [FIELD_W-1:0]   cfg_data;
	int                   fail_count;
	int                   pending;
	bit                   steady;
	int                   stall_left;
	int                   rx_gap;

	deg_in_if  evt_ch();
	deg_out_if env_ch();

	dual_envelope_generator_top #(.LEVEL_FRAC_BITS(FRAC_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.evt      (evt_ch),
		.env      (env_ch)
	);

	deg_env_checker #(.LEVEL_FRAC_BITS(FRAC_BITS)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.evt        (evt_ch),
		.env        (env_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [FIELD_W-1:0] mid_coef();
		return {1'($urandom_range(0, 1)), 24'($urandom_range(1 << 20, 24'hFFFFFF))};
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			env_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			rx_gap = pick_gap(steady);
			if (rx_gap == 0) begin
				env_ch.ready <= 1'b1;
			end else begin
				env_ch.ready <= 1'b0;
				stall_left   <= rx_gap - 1;
			end
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic rt);
		int idle;
		idle = pick_gap(steady);
		if (idle > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		evt_ch.valid     <= 1'b1;
		evt_ch.op        <= op;
		evt_ch.retrigger <= rt;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic program_phase(input int p);
		logic [FIELD_W-1:0] k_att, k_dec, k_rel, k_fa, k_fr, sus;
		case (p)
		1: begin
			k_att = 25'h0FFFFFF;
			k_dec = 25'h0FFFFFF;
			k_rel = 25'h0FFFFFF;
			k_fa  = 25'h0FFFFFF;
			k_fr  = 25'h0FFFFFF;
			sus   = 25'h1000000;
		end
		2: begin
			k_att = '0;
			k_dec = '0;
			k_rel = '0;
			k_fa  = '0;
			k_fr  = '0;
			sus   = '0;
		end
		default: begin
			k_att = mid_coef();
			k_dec = mid_coef();
			k_rel = mid_coef();
			k_fa  = mid_coef();
			k_fr  = mid_coef();
			if (p == 3)
				sus = '1;
			else if ($urandom_range(0, 4) == 0)
				sus = FIELD_W'($urandom_range(0, 25'h1FFFFFF));
			else
				sus = FIELD_W'($urandom_range(0, 1 << 24));
		end
		endcase
		write_reg(CFG_AMP_ATTACK, k_att);
		write_reg(CFG_AMP_DECAY, k_dec);
		write_reg(CFG_AMP_RELEASE, k_rel);
		write_reg(CFG_AMP_SUSTAIN, sus);
		write_reg(CFG_FLT_ATTACK, k_fa);
		write_reg(CFG_FLT_RELEASE, k_fr);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("dual_envelope_generator_top: mismatch");
		$finish;
	end

	initial begin
		int sent, budget, hold, tail;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = CFG_AMP_ATTACK;
		cfg_data         = '0;
		evt_ch.valid     = 1'b0;
		evt_ch.op        = OP_TICK;
		evt_ch.retrigger = 1'b0;
		env_ch.ready     = 1'b0;
		stall_left       = 0;
		steady           = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				evt_ch.valid <= 1'b0;
				while (pending != 0) @(negedge clk);
				repeat (4) @(negedge clk);
				program_phase(p);
			end
			steady = ($urandom_range(0, 3) == 0);
			if (p == 0) begin
				// idle voice: tick, unused code, note off, stray retrigger
				send_word(OP_TICK, 1'b1);
				send_word(OP_TICK, 1'b0);
				send_word(OP_SPARE, 1'b0);
				send_word(OP_NOTE_OFF, 1'b0);
				send_word(OP_NOTE_ON, 1'b0);
				repeat (3) send_word(OP_TICK, 1'b0);
				send_word(OP_NOTE_ON, 1'b0);
				send_word(OP_TICK, 1'b1);
				send_word(OP_NOTE_OFF, 1'b0);
				send_word(OP_TICK, 1'b0);
				// note on during release keeps the level
				send_word(OP_NOTE_ON, 1'b0);
				send_word(OP_TICK, 1'b0);
				send_word(OP_NOTE_ON, 1'b1);
				send_word(OP_TICK, 1'b0);
				send_word(OP_SPARE, 1'b1);
				send_word(OP_NOTE_OFF, 1'b1);
				repeat (2) send_word(OP_TICK, 1'b0);
				send_word(OP_NOTE_ON, 1'b1);
			end
			budget = (p == 0) ? 125 : (p == 1) ? 220 : (p == 2) ? 60 : 165;
			sent = 0;
			while (sent < budget) begin
				if ($urandom_range(0, 99) < 80) begin
					hold = $urandom_range(0, 40);
					tail = $urandom_range(0, 60);
					send_word(OP_NOTE_ON, 1'($urandom_range(0, 1)));
					repeat (hold) send_word(OP_TICK, 1'($urandom_range(0, 1)));
					send_word(OP_NOTE_OFF, 1'($urandom_range(0, 1)));
					repeat (tail) send_word(OP_TICK, 1'($urandom_range(0, 1)));
					sent += hold + tail + 2;
				end else begin
					send_word(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end
		end

		evt_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("dual_envelope_generator_top: match");
		else
			$display("dual_envelope_generator_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
